// ===== rtl/tstm_pkg.sv =====
// ----------------------------------------------------------------------------
// tstm_pkg
// Types, register indexes and constants of the trapezoid span texture mapper.
// ----------------------------------------------------------------------------
package tstm_pkg;

   // register indexes of the write port
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_PAIR     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UV_START_PAIR = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UV_DELTA_PAIR = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXTURE_BASE  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_ROW       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_ROWS     = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RENDER_SCALE  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAT_FILL     = 4'd7;

   localparam logic [15:0] TEX_ROW_MASK = 16'hff00;

   // widths of the interpolation path
   localparam int MAG_W      = 27;   // |right - left| of a coordinate, also quotient width
   localparam int DVS_W      = 20;   // span width and pixel position
   localparam int RECIP_SH   = 28;   // fraction bits of the scale reciprocal
   localparam int DIV_STEPS  = 3;    // quotient bits per divider stage
   localparam int DIV_STAGES = MAG_W / DIV_STEPS;
   localparam int FRONT_STAGES = 5;
   localparam int NUM_STAGES = FRONT_STAGES + DIV_STAGES + 1;

   typedef struct packed {
      logic [9:0] row;
      logic [9:0] col;
   } req_type;

   typedef struct packed {
      logic        inside_res;
      logic [19:0] fb_offset;
      logic [31:0] tex_address;
      logic        flat_mode;
      logic [7:0]  color;
   } rsp_type;

   // primitive as the datapath sees it; coordinate order: u left, v left, u right, v right
   typedef struct packed {
      logic [1:0][15:0] x;
      logic [1:0][15:0] slope;
      logic [3:0][15:0] start;
      logic [3:0][15:0] delta;
      logic [7:0]       top_row;
      logic [7:0]       span_rows;
      logic [2:0]       scale;
   } cfg_type;

   // one item inside the divider; coordinate 0 is u, 1 is v
   typedef struct packed {
      logic                        in_span;
      logic [19:0]                 fb;
      logic [1:0][15:0]            a_lo;
      logic [1:0]                  neg;
      logic [DVS_W-1:0]            w;
      logic [1:0][DVS_W-1:0]       rem;
      logic [1:0][MAG_W-1:0]       work;
   } div_type;

   // floor(2^28 / s)
   function automatic logic [RECIP_SH:0] scale_recip(input logic [2:0] s);
      logic [RECIP_SH:0] r;
      case (s)
         3'd2:    r = 29'd134217728;
         3'd3:    r = 29'd89478485;
         3'd4:    r = 29'd67108864;
         3'd5:    r = 29'd53687091;
         3'd6:    r = 29'd44739242;
         3'd7:    r = 29'd38347922;
         default: r = 29'd268435456;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/trapezoid_span_texture_mapper.sv =====
// ----------------------------------------------------------------------------
// trapezoid_span_texture_mapper
// Per-pixel trapezoid rasterizer with affine texel addressing or flat fill.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low and returns one result
// per request, in order, through its pipeline: five stages walk
// the edges, test the pixel and form the interpolation numerator, nine stages
// of a restoring divider produce three quotient bits each for u and v, and
// the output register composes the texel address. Stalls hold the pipeline
// but empty stages still fill. Registers may be written only while no
// request is in flight.
module trapezoid_span_texture_mapper #(
   parameter int LINE_PIXELS = 240,
   parameter int MAX_SCALE   = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tstm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tstm_pkg::rsp_type                rsp_data,
   input  logic                             csr_wr_en,
   input  logic [tstm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [63:0]                      csr_wdata
);

   localparam int NS = tstm_pkg::NUM_STAGES;
   localparam int FS = tstm_pkg::FRONT_STAGES;
   localparam int DS = tstm_pkg::DIV_STAGES;

   logic [63:0] edge_pair_ff, uv_start_pair_ff, uv_delta_pair_ff;
   logic [31:0] texture_base_ff;
   logic [7:0]  top_row_ff, span_rows_ff;
   logic [2:0]  render_scale_ff;
   logic [8:0]  flat_fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_pair_ff     <= '0;
         uv_start_pair_ff <= '0;
         uv_delta_pair_ff <= '0;
         texture_base_ff  <= '0;
         top_row_ff       <= '0;
         span_rows_ff     <= '0;
         render_scale_ff  <= 3'd1;
         flat_fill_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            tstm_pkg::CSR_EDGE_PAIR:     edge_pair_ff     <= csr_wdata;
            tstm_pkg::CSR_UV_START_PAIR: uv_start_pair_ff <= csr_wdata;
            tstm_pkg::CSR_UV_DELTA_PAIR: uv_delta_pair_ff <= csr_wdata;
            tstm_pkg::CSR_TEXTURE_BASE:  texture_base_ff  <= csr_wdata[31:0];
            tstm_pkg::CSR_TOP_ROW:       top_row_ff       <= csr_wdata[7:0];
            tstm_pkg::CSR_SPAN_ROWS:     span_rows_ff     <= csr_wdata[7:0];
            tstm_pkg::CSR_RENDER_SCALE:  render_scale_ff  <= csr_wdata[2:0];
            tstm_pkg::CSR_FLAT_FILL:     flat_fill_ff     <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   tstm_pkg::cfg_type cfg;

   always_comb begin
      cfg.x[0]     = edge_pair_ff[31:16];
      cfg.slope[0] = edge_pair_ff[15:0];
      cfg.x[1]     = edge_pair_ff[63:48];
      cfg.slope[1] = edge_pair_ff[47:32];
      cfg.start[0] = uv_start_pair_ff[31:16];
      cfg.start[1] = uv_start_pair_ff[15:0];
      cfg.start[2] = uv_start_pair_ff[63:48];
      cfg.start[3] = uv_start_pair_ff[47:32];
      cfg.delta[0] = uv_delta_pair_ff[31:16];
      cfg.delta[1] = uv_delta_pair_ff[15:0];
      cfg.delta[2] = uv_delta_pair_ff[63:48];
      cfg.delta[3] = uv_delta_pair_ff[47:32];
      cfg.top_row   = top_row_ff;
      cfg.span_rows = span_rows_ff;
      if (render_scale_ff == 3'd0) begin
         cfg.scale = 3'd1;
      end else if (int'(render_scale_ff) > MAX_SCALE) begin
         cfg.scale = 3'(MAX_SCALE);
      end else begin
         cfg.scale = render_scale_ff;
      end
   end

   logic [NS-1:0] stage_en;

   tstm_pipe_ctl #(
      .STAGES(NS)
   ) u_ctl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .out_stall(rsp_stall),
      .in_stall (req_stall),
      .stage_en (stage_en),
      .out_valid(rsp_valid)
   );

   tstm_pkg::div_type chain [DS+1];

   tstm_front #(
      .LINE_PIXELS(LINE_PIXELS)
   ) u_front (
      .clock   (clock),
      .stage_en(stage_en[FS-1:0]),
      .req     (req_data),
      .cfg     (cfg),
      .dout    (chain[0])
   );

   for (genvar g = 0; g < DS; g++) begin : g_div
      tstm_div_stage u_div (
         .clock   (clock),
         .stage_en(stage_en[FS+g]),
         .din     (chain[g]),
         .dout    (chain[g+1])
      );
   end

   // output stage: sign of the quotient, then the texel address or the flat fill
   tstm_pkg::rsp_type rsp_ff, rsp_in;
   tstm_pkg::div_type fin;
   logic [15:0]       qs [2], coord [2];

   always_comb begin
      fin = chain[DS];
      for (int c = 0; c < 2; c++) begin
         qs[c]    = fin.neg[c] ? 16'(-fin.work[c][15:0]) : fin.work[c][15:0];
         coord[c] = fin.a_lo[c] + qs[c];
      end
      rsp_in = '0;
      if (fin.in_span) begin
         rsp_in.inside_res = 1'b1;
         rsp_in.fb_offset  = fin.fb;
         if (flat_fill_ff[8]) begin
            rsp_in.flat_mode = 1'b1;
            rsp_in.color     = flat_fill_ff[7:0];
         end else begin
            rsp_in.tex_address = texture_base_ff
                               + {16'b0, coord[1] & tstm_pkg::TEX_ROW_MASK}
                               + {24'b0, coord[0][15:8]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[NS-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/tstm_pipe_ctl.sv =====
// ----------------------------------------------------------------------------
// tstm_pipe_ctl
// Valid bits and stage enables of the pipeline; a stage loads when it is
// empty or when the stage after it moves.
// ----------------------------------------------------------------------------
module tstm_pipe_ctl #(
   parameter int STAGES = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              out_stall,
   output logic              in_stall,
   output logic [STAGES-1:0] stage_en,
   output logic              out_valid
);

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES:0]   ready;

   always_comb begin
      ready[STAGES] = !out_stall;
      for (int k = STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = in_valid;
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign stage_en  = ready[STAGES-1:0];
   assign in_stall  = !ready[0];
   assign out_valid = valid_ff[STAGES-1];

endmodule

// ===== rtl/tstm_front.sv =====
// ----------------------------------------------------------------------------
// tstm_front
// Edge walk, inside test, frame buffer offset, per-row u/v at both edges
// and the numerator of the span interpolation, in five stages.
// ----------------------------------------------------------------------------
module tstm_front #(
   parameter int LINE_PIXELS = 240
) (
   input  logic             clock,
   input  logic [4:0]       stage_en,
   input  tstm_pkg::req_type req,
   input  tstm_pkg::cfg_type cfg,
   output tstm_pkg::div_type dout
);

   localparam int MW = tstm_pkg::MAG_W;
   localparam int DW = tstm_pkg::DVS_W;
   localparam int RS = tstm_pkg::RECIP_SH;

   // stage 1
   logic [18:0]        xs_ff [2], xs_in [2];
   logic signed [26:0] sr_ff [2], sr_in [2];
   logic signed [25:0] dm_ff [4], dm_in [4];
   logic [11:0]        rowabs_ff, rowabs_in;
   logic               span1_ff, span1_in;
   logic [9:0]         col1_ff;
   // stage 2
   logic signed [18:0] edge_ff [2], edge_in [2];
   logic [24:0]        dmag_ff [4], dmag_in [4];
   logic [24:0]        q0_ff [4], q0_in [4];
   logic [3:0]         dsign_ff;
   logic [19:0]        fb2_ff, fb2_in;
   logic               span2_ff;
   logic [9:0]         col2_ff;
   // stage 3
   logic               inside3_ff, inside3_in;
   logic [DW-1:0]      w3_ff, w3_in, pos3_ff, pos3_in;
   logic signed [25:0] tq_ff [4], tq_in [4];
   logic [19:0]        fb3_ff;
   // stage 4
   logic               inside4_ff;
   logic [DW-1:0]      w4_ff, pos4_ff;
   logic [19:0]        fb4_ff;
   logic [MW-1:0]      mag_ff [2], mag_in [2];
   logic [1:0]         neg4_ff, neg4_in;
   logic [15:0]        alo4_ff [2], alo4_in [2];
   // stage 5
   logic [2*MW-8:0]    prod_ff [2], prod_in [2];
   logic               inside5_ff;
   logic [DW-1:0]      w5_ff;
   logic [19:0]        fb5_ff;
   logic [1:0]         neg5_ff;
   logic [15:0]        alo5_ff [2];

   logic signed [26:0] esum [2];
   logic [53:0]        rprod [4];
   logic [RS:0]        recip;
   logic [19:0]        stride;
   logic signed [19:0] colx, leftx, rightx;
   logic [24:0]        rem_c [4], qc [4];
   logic signed [26:0] a_c [2], b_c [2];
   logic signed [27:0] diff [2];

   // stage 1: products against the row
   always_comb begin
      for (int e = 0; e < 2; e++) begin
         xs_in[e] = 19'(cfg.x[e]) * 19'(cfg.scale);
         sr_in[e] = 27'($signed(cfg.slope[e])) * 27'($signed({1'b0, req.row}));
      end
      for (int k = 0; k < 4; k++) begin
         dm_in[k] = 26'($signed(cfg.delta[k])) * 26'($signed({1'b0, req.row}));
      end
      rowabs_in = 12'(cfg.top_row) * 12'(cfg.scale) + 12'(req.row);
      span1_in  = 11'(req.row) < 11'(cfg.span_rows) * 11'(cfg.scale);
   end

   // stage 2: edges (floor by 256), offset, quotient estimate of delta*row/s
   always_comb begin
      recip  = tstm_pkg::scale_recip(cfg.scale);
      stride = 20'(LINE_PIXELS) * 20'(cfg.scale);
      for (int e = 0; e < 2; e++) begin
         esum[e]    = $signed({8'b0, xs_ff[e]}) + sr_ff[e];
         edge_in[e] = esum[e][26:8];
      end
      for (int k = 0; k < 4; k++) begin
         dmag_in[k] = dm_ff[k][25] ? 25'(-dm_ff[k]) : 25'(dm_ff[k]);
         rprod[k]   = 54'(dmag_in[k]) * 54'(recip);
         q0_in[k]   = rprod[k][RS+24:RS];
      end
      fb2_in = 20'(20'(rowabs_ff) * stride) + 20'(col1_ff);
   end

   // stage 3: inside test, span width, corrected per-row deltas
   always_comb begin
      colx   = $signed({10'b0, col2_ff});
      leftx  = 20'(edge_ff[0]);
      rightx = 20'(edge_ff[1]);
      inside3_in = span2_ff && (colx >= leftx) && (colx < rightx);
      w3_in      = 20'(rightx - leftx);
      pos3_in    = 20'(colx - leftx);
      for (int k = 0; k < 4; k++) begin
         rem_c[k] = dmag_ff[k] - 25'(q0_ff[k] * 25'(cfg.scale));
         qc[k]    = q0_ff[k] + ((rem_c[k] >= 25'(cfg.scale)) ? 25'd1 : 25'd0);
         tq_in[k] = dsign_ff[k] ? -$signed({1'b0, qc[k]}) : $signed({1'b0, qc[k]});
      end
   end

   // stage 4: coordinate at both edges and their difference
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         a_c[c]    = $signed({11'b0, cfg.start[c]}) + 27'(tq_ff[c]);
         b_c[c]    = $signed({11'b0, cfg.start[c+2]}) + 27'(tq_ff[c+2]);
         diff[c]   = 28'(b_c[c]) - 28'(a_c[c]);
         neg4_in[c] = diff[c][27];
         mag_in[c] = diff[c][27] ? MW'(-diff[c]) : MW'(diff[c]);
         alo4_in[c] = a_c[c][15:0];
      end
   end

   // stage 5: numerator |b - a| * pos
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         prod_in[c] = (2*MW-7)'(mag_ff[c]) * (2*MW-7)'(pos4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         xs_ff     <= xs_in;
         sr_ff     <= sr_in;
         dm_ff     <= dm_in;
         rowabs_ff <= rowabs_in;
         span1_ff  <= span1_in;
         col1_ff   <= req.col;
      end
      if (stage_en[1]) begin
         edge_ff  <= edge_in;
         dmag_ff  <= dmag_in;
         q0_ff    <= q0_in;
         for (int k = 0; k < 4; k++) begin
            dsign_ff[k] <= dm_ff[k][25];
         end
         fb2_ff   <= fb2_in;
         span2_ff <= span1_ff;
         col2_ff  <= col1_ff;
      end
      if (stage_en[2]) begin
         inside3_ff <= inside3_in;
         w3_ff      <= w3_in;
         pos3_ff    <= pos3_in;
         tq_ff      <= tq_in;
         fb3_ff     <= fb2_ff;
      end
      if (stage_en[3]) begin
         inside4_ff <= inside3_ff;
         w4_ff      <= w3_ff;
         pos4_ff    <= pos3_ff;
         fb4_ff     <= fb3_ff;
         mag_ff     <= mag_in;
         neg4_ff    <= neg4_in;
         alo4_ff    <= alo4_in;
      end
      if (stage_en[4]) begin
         prod_ff    <= prod_in;
         inside5_ff <= inside4_ff;
         w5_ff      <= w4_ff;
         fb5_ff     <= fb4_ff;
         neg5_ff    <= neg4_ff;
         alo5_ff    <= alo4_ff;
      end
   end

   // quotient is below 2^MW, so the top part of the numerator starts as remainder
   always_comb begin
      dout.in_span = inside5_ff;
      dout.fb      = fb5_ff;
      dout.neg     = neg5_ff;
      dout.w       = w5_ff;
      for (int c = 0; c < 2; c++) begin
         dout.a_lo[c] = alo5_ff[c];
         dout.rem[c]  = prod_ff[c][2*MW-8:MW];
         dout.work[c] = prod_ff[c][MW-1:0];
      end
   end

endmodule

// ===== rtl/tstm_div_stage.sv =====
// ----------------------------------------------------------------------------
// tstm_div_stage
// One stage of the restoring span divider: a few quotient bits for u and v.
// ----------------------------------------------------------------------------
module tstm_div_stage (
   input  logic              clock,
   input  logic              stage_en,
   input  tstm_pkg::div_type din,
   output tstm_pkg::div_type dout
);

   localparam int MW = tstm_pkg::MAG_W;
   localparam int DW = tstm_pkg::DVS_W;

   tstm_pkg::div_type stage_ff, stage_in;
   logic [DW:0]       rr;
   logic              qbit;

   always_comb begin
      rr       = '0;
      qbit     = 1'b0;
      stage_in = din;
      for (int c = 0; c < 2; c++) begin
         for (int s = 0; s < tstm_pkg::DIV_STEPS; s++) begin
            rr   = {stage_in.rem[c], stage_in.work[c][MW-1]};
            qbit = rr >= {1'b0, din.w};
            stage_in.rem[c]  = qbit ? DW'(rr - {1'b0, din.w}) : rr[DW-1:0];
            stage_in.work[c] = {stage_in.work[c][MW-2:0], qbit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         stage_ff <= stage_in;
      end
   end

   assign dout = stage_ff;

endmodule

// ===== bench/trapezoid_span_texture_mapper_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoid_span_texture_mapper_tb
// Drives pixel requests through the trapezoid rasterizer under several
// primitives and scales. Every result is checked against an in-bench
// predictor, in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module trapezoid_span_texture_mapper_tb;

   localparam int LINE_PX  = 240;
   localparam int SCALE_MAX = 4;
   localparam int SETTLE   = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tstm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tstm_pkg::rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [tstm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   trapezoid_span_texture_mapper dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // primitive copy for the predictor
   logic [63:0] p_edge, p_uvs, p_uvd;
   logic [31:0] p_base;
   logic [7:0]  p_top, p_rows;
   logic [2:0]  p_scale;
   logic [8:0]  p_fill;

   tstm_pkg::req_type pending_pixels[$];
   tstm_pkg::rsp_type expected_pixels[$];
   int errors = 0;
   int checked = 0;
   int inside_seen = 0;
   int gap_cnt = 0;
   int hold_cnt = 0;
   int long_hold = 0;
   bit csr_busy = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint sx16(logic [15:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint floor256(longint v);
      if (v >= 0) return v / 256;
      return -((-v + 255) / 256);
   endfunction

   function automatic longint blend(logic [15:0] sl, logic [15:0] sr, logic [15:0] dl,
                                    logic [15:0] dr, longint s, longint row,
                                    longint pos, longint w);
      longint a, b;
      a = longint'(sl) + (sx16(dl) * row) / s;
      b = longint'(sr) + (sx16(dr) * row) / s;
      return a + ((b - a) * pos) / w;
   endfunction

   function automatic tstm_pkg::rsp_type predict_pixel(tstm_pkg::req_type r);
      tstm_pkg::rsp_type o;
      longint row, col, s, left, right, w, pos, fb;
      logic [31:0] el, er, sl, sr, dl, dr;
      logic [15:0] u, v;
      o = '0;
      row = r.row; col = r.col;
      s = p_scale;
      if (s < 1) s = 1;
      if (s > SCALE_MAX) s = SCALE_MAX;
      el = p_edge[31:0]; er = p_edge[63:32];
      sl = p_uvs[31:0];  sr = p_uvs[63:32];
      dl = p_uvd[31:0];  dr = p_uvd[63:32];
      if (row >= longint'(p_rows) * s) return o;
      left  = floor256(longint'(el[31:16]) * s + sx16(el[15:0]) * row);
      right = floor256(longint'(er[31:16]) * s + sx16(er[15:0]) * row);
      if (!(col >= left && col < right)) return o;
      o.inside_res = 1'b1;
      fb = (longint'(p_top) * s + row) * (LINE_PX * s) + col;
      o.fb_offset = fb[19:0];
      if (p_fill[8]) begin
         o.flat_mode = 1'b1;
         o.color = p_fill[7:0];
         return o;
      end
      w = right - left;
      pos = col - left;
      u = 16'(blend(sl[31:16], sr[31:16], dl[31:16], dr[31:16], s, row, pos, w));
      v = 16'(blend(sl[15:0], sr[15:0], dl[15:0], dr[15:0], s, row, pos, w));
      o.tex_address = p_base + {16'h0, v & tstm_pkg::TEX_ROW_MASK} + {24'h0, u[15:8]};
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %0s: got %0h expected %0h (result %0d)", what, got, want, checked);
   endtask

   function automatic int rand_gap();
      if ($urandom_range(0, 99) < 55) return 0;
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset || csr_busy) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
         // hold the request
      end else begin
         if (req_valid) expected_pixels.push_back(predict_pixel(req_data));
         if (gap_cnt > 0) begin
            gap_cnt <= gap_cnt - 1;
            req_valid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            req_data <= pending_pixels.pop_front();
            req_valid <= 1'b1;
            gap_cnt <= rand_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected result", 0, 0);
            end else begin
               tstm_pkg::rsp_type e;
               e = expected_pixels.pop_front();
               if (rsp_data.inside_res != e.inside_res)
                  report_mismatch("inside_res", rsp_data.inside_res, e.inside_res);
               if (rsp_data.fb_offset != e.fb_offset)
                  report_mismatch("fb_offset", rsp_data.fb_offset, e.fb_offset);
               if (rsp_data.tex_address != e.tex_address)
                  report_mismatch("tex_address", rsp_data.tex_address, e.tex_address);
               if (rsp_data.flat_mode != e.flat_mode)
                  report_mismatch("flat_mode", rsp_data.flat_mode, e.flat_mode);
               if (rsp_data.color != e.color)
                  report_mismatch("color", rsp_data.color, e.color);
               if (e.inside_res) inside_seen++;
            end
            checked++;
         end
         if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            rsp_stall <= 1'b1;
         end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            hold_cnt <= rand_gap();
         end
      end
   end

   task automatic csr_write(logic [tstm_pkg::CSR_IDX_W-1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         tstm_pkg::CSR_EDGE_PAIR:     p_edge = val;
         tstm_pkg::CSR_UV_START_PAIR: p_uvs = val;
         tstm_pkg::CSR_UV_DELTA_PAIR: p_uvd = val;
         tstm_pkg::CSR_TEXTURE_BASE:  p_base = val[31:0];
         tstm_pkg::CSR_TOP_ROW:       p_top = val[7:0];
         tstm_pkg::CSR_SPAN_ROWS:     p_rows = val[7:0];
         tstm_pkg::CSR_RENDER_SCALE:  p_scale = val[2:0];
         tstm_pkg::CSR_FLAT_FILL:     p_fill = val[8:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_pixels.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // plausible primitive for kind 0 (edges in a few hundred columns, modest slopes)
   task automatic load_primitive(int kind);
      logic [15:0] xl, xr, sll, slr;
      xl = 16'($urandom_range(0, 16'h6000));
      xr = 16'(xl + $urandom_range(16'h0100, 16'h8000));
      sll = 16'($signed($urandom_range(0, 1024)) - 512);
      slr = 16'($signed($urandom_range(0, 1024)) - 512);
      if (kind == 1) begin
         xl = 16'hffff; xr = 16'hffff; sll = 16'h8000; slr = 16'h7fff;
      end else if (kind == 2) begin
         xl = 16'h0000; xr = 16'h0000; sll = 16'h7fff; slr = 16'h8000;
      end else if (kind == 3) begin
         xl = 16'($urandom); xr = 16'($urandom); sll = 16'($urandom); slr = 16'($urandom);
      end
      csr_write(tstm_pkg::CSR_EDGE_PAIR, {xr, slr, xl, sll});
      csr_write(tstm_pkg::CSR_UV_START_PAIR, {$urandom, $urandom});
      csr_write(tstm_pkg::CSR_UV_DELTA_PAIR, {$urandom, $urandom});
      csr_write(tstm_pkg::CSR_TEXTURE_BASE, kind == 1 ? 64'hffff_ffff : {32'h0, $urandom});
      csr_write(tstm_pkg::CSR_TOP_ROW,
                64'(kind == 1 ? 159 : (kind == 2 ? 0 : $urandom_range(0, 159))));
      csr_write(tstm_pkg::CSR_SPAN_ROWS,
                64'(kind == 1 ? 160 : (kind == 2 ? 0 : $urandom_range(1, 160))));
      csr_write(tstm_pkg::CSR_RENDER_SCALE,
                64'(kind == 3 ? $urandom_range(0, 7) : $urandom_range(1, 4)));
      csr_write(tstm_pkg::CSR_FLAT_FILL, 64'($urandom_range(0, 511)));
   endtask

   // mostly pixels near the live span, some anywhere
   task automatic queue_pixels(int n);
      tstm_pkg::req_type r;
      int s, lft;
      s = (p_scale == 0) ? 1 : (p_scale > SCALE_MAX ? SCALE_MAX : p_scale);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 80) begin
            r.row = 10'($urandom_range(0, p_rows * s + 2));
            lft = (p_edge[31:16] * s) >> 8;
            r.col = 10'(lft + $urandom_range(0, ((p_edge[63:48] * s) >> 8) - lft + 4));
         end else begin
            r = tstm_pkg::req_type'(20'($urandom));
         end
         pending_pixels.push_back(r);
      end
   endtask

   initial begin
      tstm_pkg::req_type r;
      p_edge = 0; p_uvs = 0; p_uvd = 0; p_base = 0;
      p_top = 0; p_rows = 0; p_scale = 1; p_fill = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset values: nothing inside
      r.row = 0; r.col = 0; pending_pixels.push_back(r);
      drain();

      // directed span: texture at scales 0, 1, 4, 7 (0, 7 out of range), flat at 2
      csr_busy = 1;
      csr_write(tstm_pkg::CSR_EDGE_PAIR, {16'h5000, 16'h0040, 16'h1000, 16'hffc0});
      csr_write(tstm_pkg::CSR_UV_START_PAIR, {16'hff00, 16'h80ff, 16'h0000, 16'h0000});
      csr_write(tstm_pkg::CSR_UV_DELTA_PAIR, {16'h8000, 16'h7fff, 16'h0100, 16'hff00});
      csr_write(tstm_pkg::CSR_TEXTURE_BASE, 64'h0600_0000);
      csr_write(tstm_pkg::CSR_TOP_ROW, 64'd159);
      csr_write(tstm_pkg::CSR_SPAN_ROWS, 64'd20);
      csr_write(4'd9, 64'hdead);   // unknown index is ignored
      for (int sc = 0; sc < 8; sc += 1) begin
         if (!(sc inside {0, 1, 2, 4, 7})) continue;
         csr_write(tstm_pkg::CSR_RENDER_SCALE, 64'(sc));
         csr_write(tstm_pkg::CSR_FLAT_FILL, (sc == 2) ? 64'h1a5 : 64'h0ff);
         csr_busy = 0;
         r.row = 0; r.col = 16; pending_pixels.push_back(r);        // left edge, s=1
         r.row = 0; r.col = 15; pending_pixels.push_back(r);        // just left, s=1
         r.row = 0; r.col = 79; pending_pixels.push_back(r);        // last inside, s=1
         r.row = 0; r.col = 80; pending_pixels.push_back(r);        // right edge, s=1
         r.row = 19; r.col = 40; pending_pixels.push_back(r);
         r.row = 10'd1023; r.col = 10'd1023; pending_pixels.push_back(r);
         r.row = 10'(20 * (sc == 0 ? 1 : sc > 4 ? 4 : sc)); r.col = 40;
         pending_pixels.push_back(r);
         drain();
         csr_busy = 1;
      end
      csr_busy = 0;

      // random phases: extremes, inverted, random, then plausible, every sixth random
      for (int ph = 0; ph < 24; ph++) begin
         csr_busy = 1;
         load_primitive(ph < 3 ? ph + 1 : (ph % 6 == 5 ? 3 : 0));
         csr_busy = 0;
         queue_pixels(85);
         if (ph == 6) begin
            // receiver holds off while the sender keeps offering
            wait (pending_pixels.size() < 70);
            long_hold = 200;
         end
         drain();
      end

      $display("checked %0d results, %0d of them inside, over 24 random primitives",
               checked, inside_seen);
      if (errors == 0)
         $display("PASS trapezoid_span_texture_mapper");
      else
         $display("FAIL trapezoid_span_texture_mapper");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL trapezoid_span_texture_mapper");
      $finish;
   end

endmodule
